[hw/rtl/bpsr_pkg.sv]
// Shared constants for the BMP pixel stream to RGB565 decoder.
// No dependencies; used by every module of the block except bpsr_fifo.
`default_nettype none

package bpsr_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int HELD_BITS  = 16;
    localparam int COLOR_BITS = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam logic MODE_24 = 1'b0;
    localparam logic MODE_16 = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_MODE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y     = 3'd4;

    localparam logic [1:0] PH_EMPTY = 2'd0;
    localparam logic [1:0] PH_ONE   = 2'd1;
    localparam logic [1:0] PH_TWO   = 2'd2;

    localparam int RESET_WIDTH  = 240;
    localparam int RESET_HEIGHT = 320;

endpackage

`default_nettype wire

[hw/rtl/bpsr_fifo.sv]
// Small register queue used between the decoder stages and on the result side.
// No package dependencies.
`default_nettype none

module bpsr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bpsr_front.sv]
// Front stage: gathers pixel bytes, skips row padding and tracks the position.
// Depends on bpsr_pkg; feeds a pixel record word to the middle queue.
`default_nettype none

module bpsr_front #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_byte_vld,
    input  wire logic [bpsr_pkg::BYTE_BITS-1:0]      i_data_byte,
    input  wire logic                                i_pixel_mode,
    input  wire logic [COORD_BITS-1:0]               i_image_width,
    input  wire logic [COORD_BITS-1:0]               i_image_height,
    output logic                                     o_q_push,
    output logic [2*COORD_BITS+bpsr_pkg::BYTE_BITS+bpsr_pkg::HELD_BITS+1:0] o_q_data
);

    logic [1:0]                     r_phase, n_phase;
    logic [bpsr_pkg::HELD_BITS-1:0] r_held, n_held;
    logic [COORD_BITS-1:0]          r_col, n_col;
    logic [COORD_BITS-1:0]          r_row, n_row;
    logic [1:0]                     r_pad, n_pad;
    logic                           r_finished, n_finished;

    logic [COORD_BITS-1:0] w, h, row_clamp;
    logic                  last_col, last_row, done;
    logic [1:0]            row_bytes_lo;

    assign w = (i_image_width == '0) ? COORD_BITS'(1) : i_image_width;
    assign h = (i_image_height == '0) ? COORD_BITS'(1) : i_image_height;
    assign last_col = ({1'b0, r_col} + 1'b1) >= {1'b0, w};
    assign last_row = ({1'b0, r_row} + 1'b1) >= {1'b0, h};
    assign row_clamp = (r_row < h) ? r_row : h - 1'b1;
    assign row_bytes_lo = (i_pixel_mode == bpsr_pkg::MODE_16) ? {w[0], 1'b0}
                        : w[1:0] + {w[0], 1'b0};

    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        n_col      = r_col;
        n_row      = r_row;
        n_pad      = r_pad;
        n_finished = r_finished;
        o_q_push   = 1'b0;
        done       = 1'b0;
        if (i_byte_vld && !r_finished) begin
            if (r_pad != 2'd0) begin
                n_pad = r_pad - 1'b1;
            end else if (r_phase == bpsr_pkg::PH_EMPTY) begin
                n_held  = {8'h00, i_data_byte};
                n_phase = bpsr_pkg::PH_ONE;
            end else if (i_pixel_mode == bpsr_pkg::MODE_24 && r_phase == bpsr_pkg::PH_ONE) begin
                n_held  = {i_data_byte, r_held[7:0]};
                n_phase = bpsr_pkg::PH_TWO;
            end else begin
                o_q_push = 1'b1;
                n_phase  = bpsr_pkg::PH_EMPTY;
                n_held   = '0;
                if (last_col) begin
                    n_col = '0;
                    n_pad = 2'd0 - row_bytes_lo;
                    n_row = r_row + 1'b1;
                    if (last_row) begin
                        n_finished = 1'b1;
                        done       = 1'b1;
                        n_pad      = 2'd0;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    assign o_q_data = {i_pixel_mode, i_data_byte, r_held, r_col, row_clamp, done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= bpsr_pkg::PH_EMPTY;
            r_held     <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_pad      <= 2'd0;
            r_finished <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_held     <= n_held;
            r_col      <= n_col;
            r_row      <= n_row;
            r_pad      <= n_pad;
            r_finished <= n_finished;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bpsr_back.sv]
// Back stage: packs a pixel record into RGB565 and forms its screen position.
// Depends on bpsr_pkg; reads the middle queue and fills the result queue.
`default_nettype none

module bpsr_back #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                i_q_empty,
    input  wire logic [2*COORD_BITS+bpsr_pkg::BYTE_BITS+bpsr_pkg::HELD_BITS+1:0] i_q_data,
    output logic                                     o_q_pop,
    input  wire logic [COORD_BITS-1:0]               i_image_height,
    input  wire logic [COORD_BITS-1:0]               i_origin_x,
    input  wire logic [COORD_BITS-1:0]               i_origin_y,
    input  wire logic                                i_oq_full,
    output logic                                     o_oq_push,
    output logic [2*COORD_BITS+bpsr_pkg::COLOR_BITS+3:0] o_oq_data
);

    logic                           mode;
    logic [bpsr_pkg::BYTE_BITS-1:0] last_byte;
    logic [bpsr_pkg::HELD_BITS-1:0] held, src;
    logic [COORD_BITS-1:0]          col, row, h, rows_below;
    logic                           done, warn;
    logic [bpsr_pkg::COLOR_BITS-1:0] color;
    logic [COORD_BITS:0]            x, y;

    assign {mode, last_byte, held, col, row, done} = i_q_data;

    assign src = {last_byte, held[7:0]};
    assign h = (i_image_height == '0) ? COORD_BITS'(1) : i_image_height;
    assign rows_below = h - 1'b1 - row;

    always_comb begin
        if (mode == bpsr_pkg::MODE_16) begin
            color = {src[14:4], src[4:0]};
            warn  = src[15];
        end else begin
            color = {last_byte[7:3], held[15:10], held[7:3]};
            warn  = 1'b0;
        end
    end

    assign x = {1'b0, i_origin_x} + {1'b0, col};
    assign y = {1'b0, i_origin_y} + {1'b0, rows_below};

    assign o_q_pop   = !i_q_empty && !i_oq_full;
    assign o_oq_push = o_q_pop;
    assign o_oq_data = {x, y, color, warn, done};

endmodule

`default_nettype wire

[hw/rtl/bmp_pixel_stream_to_rgb565.sv]
// BMP pixel-array byte stream to RGB565 pixels with screen positions.
// Takes one byte per cycle while full is low; the byte that completes a pixel
// is registered in the middle queue and then in the result queue before its
// result shows on the output ports.
// Reset (synchronous, active low) empties both queues, starts a new image and
// loads the registers with 24-bit mode, 240 x 320, origin 0,0.
`default_nettype none

module bmp_pixel_stream_to_rgb565 #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bpsr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [COORD_BITS-1:0]              i_cfg_data,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [bpsr_pkg::BYTE_BITS-1:0]     i_data_byte,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [COORD_BITS:0]                     o_screen_x,
    output logic [COORD_BITS:0]                     o_screen_y,
    output logic [bpsr_pkg::COLOR_BITS-1:0]         o_color565,
    output logic                                    o_top_bit_warning,
    output logic                                    o_image_done
);

    localparam int MID_W = 2*COORD_BITS + bpsr_pkg::BYTE_BITS + bpsr_pkg::HELD_BITS + 2;
    localparam int OUT_W = 2*COORD_BITS + bpsr_pkg::COLOR_BITS + 4;

    logic                  r_pixel_mode;
    logic [COORD_BITS-1:0] r_image_width, r_image_height, r_origin_x, r_origin_y;

    logic             mid_push, mid_full, mid_pop, mid_empty;
    logic [MID_W-1:0] mid_wdata, mid_rdata;
    logic             oq_push, oq_full;
    logic [OUT_W-1:0] oq_wdata, oq_rdata;
    logic             byte_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode   <= bpsr_pkg::MODE_24;
            r_image_width  <= COORD_BITS'(bpsr_pkg::RESET_WIDTH);
            r_image_height <= COORD_BITS'(bpsr_pkg::RESET_HEIGHT);
            r_origin_x     <= '0;
            r_origin_y     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpsr_pkg::CFG_PIXEL_MODE:   r_pixel_mode   <= i_cfg_data[0];
                bpsr_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                bpsr_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                bpsr_pkg::CFG_ORIGIN_X:     r_origin_x     <= i_cfg_data;
                bpsr_pkg::CFG_ORIGIN_Y:     r_origin_y     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign full     = mid_full;
    assign byte_vld = push && !mid_full;

    bpsr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_vld     (byte_vld),
        .i_data_byte    (i_data_byte),
        .i_pixel_mode   (r_pixel_mode),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_q_push       (mid_push),
        .o_q_data       (mid_wdata)
    );

    bpsr_fifo #(.WIDTH(MID_W), .DEPTH(2)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_wdata),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_rdata),
        .o_empty (mid_empty)
    );

    bpsr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_q_empty      (mid_empty),
        .i_q_data       (mid_rdata),
        .o_q_pop        (mid_pop),
        .i_image_height (r_image_height),
        .i_origin_x     (r_origin_x),
        .i_origin_y     (r_origin_y),
        .i_oq_full      (oq_full),
        .o_oq_push      (oq_push),
        .o_oq_data      (oq_wdata)
    );

    bpsr_fifo #(.WIDTH(OUT_W), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  (oq_wdata),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (oq_rdata),
        .o_empty (empty)
    );

    assign {o_screen_x, o_screen_y, o_color565, o_top_bit_warning, o_image_done} = oq_rdata;

endmodule

`default_nettype wire

[hw/rtl/bpsr_checker.sv]
// Port-level checks for the BMP pixel stream decoder, bound to its top level.
// Depends on bpsr_pkg and bmp_pixel_stream_to_rgb565.
`default_nettype none

module bpsr_checker #(
    parameter int COORD_BITS = 12
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               full,
    input wire logic                               empty,
    input wire logic                               pop,
    input wire logic [COORD_BITS:0]                o_screen_x,
    input wire logic [COORD_BITS:0]                o_screen_y,
    input wire logic [bpsr_pkg::COLOR_BITS-1:0]    o_color565,
    input wire logic                               o_top_bit_warning,
    input wire logic                               o_image_done
);

    // A reset leaves no word waiting on the result side.
    a_reset_empty : assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    // A reset leaves room for the next byte.
    a_reset_not_full : assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    a_stall_keeps_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("waiting word dropped");

    a_stall_keeps_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> ($stable(o_screen_x) && $stable(o_screen_y)
                              && $stable(o_color565) && $stable(o_top_bit_warning)
                              && $stable(o_image_done)))
        else $error("waiting word changed");

endmodule

bind bmp_pixel_stream_to_rgb565 bpsr_checker #(.COORD_BITS(COORD_BITS)) u_bpsr_checker (.*);

`default_nettype wire

[verif/tb_top.sv]
// Testbench for bmp_pixel_stream_to_rgb565: feeds BMP pixel-array bytes, predicts each
// decoded pixel and its screen position, and checks every word that leaves the block.
// Depends on bpsr_pkg and the bmp_pixel_stream_to_rgb565 RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB          = 12;
    localparam int STUCK_LIMIT = 4000;
    localparam int RANDOM_BYTES = 1150;

    typedef struct packed {
        logic [CB:0]   x;
        logic [CB:0]   y;
        logic [15:0]   color;
        logic          warn;
        logic          done;
    } t_pixel;

    typedef struct {
        bit              is_reg;
        logic [2:0]      reg_idx;
        int unsigned     value;
        bit              typed;
        t_pixel          want;
    } t_plan_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [2:0]        i_cfg_idx = '0;
    logic [CB-1:0]     i_cfg_data = '0;
    logic              push = 1'b0;
    logic [7:0]        i_data_byte = '0;
    logic              pop = 1'b0;
    logic              full;
    logic              empty;
    logic [CB:0]       o_screen_x;
    logic [CB:0]       o_screen_y;
    logic [15:0]       o_color565;
    logic              o_top_bit_warning;
    logic              o_image_done;

    // Decoder state as the predictor sees it.
    logic              cfg_mode = bpsr_pkg::MODE_24;
    logic [CB-1:0]     cfg_width = CB'(bpsr_pkg::RESET_WIDTH);
    logic [CB-1:0]     cfg_height = CB'(bpsr_pkg::RESET_HEIGHT);
    logic [CB-1:0]     cfg_ox = '0;
    logic [CB-1:0]     cfg_oy = '0;
    logic [1:0]        pix_phase = bpsr_pkg::PH_EMPTY;
    logic [15:0]       pix_held = '0;
    logic [CB-1:0]     col_pos = '0;
    logic [CB-1:0]     row_pos = '0;
    logic [1:0]        pad_left = '0;
    logic              img_finished = 1'b0;

    t_pixel            pending_pixels[$];
    t_pixel            head_px;
    t_plan_row         plan[$];
    int                fail_count = 0;
    int                stuck_cycles = 0;
    int                burst_left = 0;
    bit                gapless = 1'b0;
    logic              hold_req = 1'b0;
    logic              hold_taken = 1'b0;
    int                hold_left = 0;
    int                rx_cycle = 0;
    int                rx_style = 0;

    bmp_pixel_stream_to_rgb565 #(.COORD_BITS(CB)) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .push              (push),
        .full              (full),
        .i_data_byte       (i_data_byte),
        .empty             (empty),
        .pop               (pop),
        .o_screen_x        (o_screen_x),
        .o_screen_y        (o_screen_y),
        .o_color565        (o_color565),
        .o_top_bit_warning (o_top_bit_warning),
        .o_image_done      (o_image_done)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit decode_byte(input logic [7:0] b, output t_pixel px);
        int unsigned w;
        int unsigned h;
        int unsigned src;
        int unsigned row_bytes;
        px = '0;
        w = (cfg_width == 0) ? 1 : cfg_width;
        h = (cfg_height == 0) ? 1 : cfg_height;
        if (img_finished) return 1'b0;
        if (pad_left != 0) begin
            pad_left = pad_left - 2'd1;
            return 1'b0;
        end
        if (pix_phase == bpsr_pkg::PH_EMPTY) begin
            pix_held = {8'h00, b};
            pix_phase = bpsr_pkg::PH_ONE;
            return 1'b0;
        end
        if (cfg_mode == bpsr_pkg::MODE_16) begin
            src = 32'({b, pix_held[7:0]});
            px.color = 16'(((src << 1) & 32'hffe0) | (src & 32'h001f));
            px.warn = src[15];
        end else if (pix_phase == bpsr_pkg::PH_ONE) begin
            pix_held[15:8] = b;
            pix_phase = bpsr_pkg::PH_TWO;
            return 1'b0;
        end else begin
            px.color = {b[7:3], pix_held[15:10], pix_held[7:3]};
        end
        pix_phase = bpsr_pkg::PH_EMPTY;
        pix_held = '0;
        px.x = {1'b0, cfg_ox} + {1'b0, col_pos};
        px.y = (CB+1)'(cfg_oy + h - 1 - ((row_pos < h) ? row_pos : h - 1));
        if (col_pos + 1 >= w) begin
            row_bytes = (cfg_mode == bpsr_pkg::MODE_16) ? w * 2 : w * 3;
            col_pos = '0;
            pad_left = 2'(4 - (row_bytes & 3));
            if (row_pos + 1 >= h) begin
                img_finished = 1'b1;
                px.done = 1'b1;
                pad_left = '0;
            end
            row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch on %s at %0t: got 0x%0h, want 0x%0h", what, $realtime, got, want);
        fail_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed, input t_pixel typed_px);
        t_pixel px;
        int gap;
        gap = 0;
        if (!gapless) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end
        i_cfg_we <= 1'b0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (full);
        if (decode_byte(b, px)) pending_pixels.push_back(typed ? typed_px : px);
    endtask

    // Registers change only with the input stopped and every pixel delivered.
    task automatic wait_idle();
        push <= 1'b0;
        i_cfg_we <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CB-1:0];
        @(posedge i_clk);
        case (idx)
            bpsr_pkg::CFG_PIXEL_MODE:   cfg_mode = val[0];
            bpsr_pkg::CFG_IMAGE_WIDTH:  cfg_width = val[CB-1:0];
            bpsr_pkg::CFG_IMAGE_HEIGHT: cfg_height = val[CB-1:0];
            bpsr_pkg::CFG_ORIGIN_X:     cfg_ox = val[CB-1:0];
            bpsr_pkg::CFG_ORIGIN_Y:     cfg_oy = val[CB-1:0];
            default: ;
        endcase
    endtask

    function automatic void add_reg(input logic [2:0] idx, input int unsigned val);
        t_plan_row r;
        r = '{is_reg: 1'b1, reg_idx: idx, value: val, typed: 1'b0, want: '0};
        plan.push_back(r);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        t_plan_row r;
        r = '{is_reg: 1'b0, reg_idx: '0, value: b, typed: 1'b0, want: '0};
        plan.push_back(r);
    endfunction

    function automatic void add_pixel_end(input logic [7:0] b, input int unsigned x,
                                          input int unsigned y, input logic [15:0] color,
                                          input logic warn);
        t_plan_row r;
        r = '{is_reg: 1'b0, reg_idx: '0, value: b, typed: 1'b1,
              want: '{x: x[CB:0], y: y[CB:0], color: color, warn: warn, done: 1'b0}};
        plan.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected word", o_color565, 0);
            end else begin
                head_px = pending_pixels.pop_front();
                if (o_screen_x !== head_px.x) report_mismatch("screen_x", o_screen_x, head_px.x);
                if (o_screen_y !== head_px.y) report_mismatch("screen_y", o_screen_y, head_px.y);
                if (o_color565 !== head_px.color)
                    report_mismatch("color565", o_color565, head_px.color);
                if (o_top_bit_warning !== head_px.warn)
                    report_mismatch("top_bit_warning", o_top_bit_warning, head_px.warn);
                if (o_image_done !== head_px.done)
                    report_mismatch("image_done", o_image_done, head_px.done);
            end
        end
    end

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0) rx_style <= $urandom_range(0, 3);
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_left <= 120;
            hold_taken <= 1'b1;
            pop <= 1'b0;
        end else begin
            case (rx_style)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 1);
                2: pop <= ((rx_cycle % 7) > 2);
                default: pop <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        bit prev_reg;
        int phase_no;
        int count;
        int random_bytes;
        int unsigned val;
        logic [7:0] b;
        prev_reg = 1'b0;
        phase_no = 0;
        random_bytes = 0;

        // Reset state: 24-bit mode, 240 x 320 at the origin, bottom row first.
        add_byte(8'hff); add_byte(8'hff); add_pixel_end(8'hff, 0, 319, 16'hffff, 1'b0);
        add_byte(8'h00); add_byte(8'h00); add_pixel_end(8'h00, 1, 319, 16'h0000, 1'b0);
        add_reg(bpsr_pkg::CFG_IMAGE_WIDTH, 3);
        add_byte(8'h08); add_byte(8'h04); add_pixel_end(8'h10, 2, 319, 16'h1021, 1'b0);
        add_byte(8'haa); add_byte(8'h55); add_byte(8'haa);
        // 16-bit mode, zero width, origin at the far corner.
        add_reg(bpsr_pkg::CFG_PIXEL_MODE, bpsr_pkg::MODE_16);
        add_reg(bpsr_pkg::CFG_IMAGE_WIDTH, 0);
        add_reg(bpsr_pkg::CFG_ORIGIN_X, 4095);
        add_reg(bpsr_pkg::CFG_ORIGIN_Y, 4095);
        add_byte(8'hff); add_pixel_end(8'hff, 4095, 4413, 16'hffff, 1'b1);
        add_byte(8'h00); add_byte(8'hff);
        add_byte(8'h00); add_pixel_end(8'h80, 4095, 4412, 16'h0000, 1'b1);
        add_byte(8'h5a); add_byte(8'ha5);
        // Mode switched with one and then two bytes of a pixel held.
        add_reg(bpsr_pkg::CFG_PIXEL_MODE, bpsr_pkg::MODE_24);
        add_reg(bpsr_pkg::CFG_IMAGE_WIDTH, 4095);
        add_reg(bpsr_pkg::CFG_ORIGIN_X, 0);
        add_reg(bpsr_pkg::CFG_ORIGIN_Y, 0);
        add_byte(8'h12);
        add_reg(bpsr_pkg::CFG_PIXEL_MODE, bpsr_pkg::MODE_16);
        add_byte(8'h34);
        add_reg(bpsr_pkg::CFG_PIXEL_MODE, bpsr_pkg::MODE_24);
        add_byte(8'h56); add_byte(8'h78);
        add_reg(bpsr_pkg::CFG_PIXEL_MODE, bpsr_pkg::MODE_16);
        add_byte(8'h9a);
        // Width dropped below the current column ends the row on the next pixel.
        add_reg(bpsr_pkg::CFG_IMAGE_WIDTH, 1);
        add_reg(bpsr_pkg::CFG_IMAGE_HEIGHT, 4095);
        add_byte(8'h01); add_byte(8'h02);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                if (!prev_reg) wait_idle();
                write_reg(plan[i].reg_idx, plan[i].value);
            end else begin
                send_byte(plan[i].value[7:0], plan[i].typed, plan[i].want);
            end
            prev_reg = plan[i].is_reg;
        end

        while (random_bytes < RANDOM_BYTES) begin
            phase_no++;
            wait_idle();
            write_reg(bpsr_pkg::CFG_PIXEL_MODE, $urandom_range(0, 1));
            if (phase_no == 1 || $urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 9))
                    0: val = 0;
                    1: val = 1;
                    2: val = 4095;
                    3: val = $urandom_range(9, 4095);
                    default: val = $urandom_range(2, 8);
                endcase
                write_reg(bpsr_pkg::CFG_IMAGE_WIDTH, val);
            end
            if (phase_no == 1 || $urandom_range(0, 1) == 1)
                write_reg(bpsr_pkg::CFG_IMAGE_HEIGHT,
                          ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(1000, 4094));
            if (phase_no == 1 || $urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 3))
                    0: val = 0;
                    1: val = 4095;
                    default: val = $urandom_range(0, 4095);
                endcase
                write_reg(bpsr_pkg::CFG_ORIGIN_X, val);
            end
            if (phase_no == 1 || $urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 3))
                    0: val = 0;
                    1: val = 4095;
                    default: val = $urandom_range(0, 4095);
                endcase
                write_reg(bpsr_pkg::CFG_ORIGIN_Y, val);
            end
            count = $urandom_range(20, 110);
            gapless = ($urandom_range(0, 3) == 0);
            if (phase_no == 3) begin
                // The receiver stops for a long stretch while bytes keep coming.
                hold_req <= 1'b1;
                gapless = 1'b1;
                count = 80;
            end
            repeat (count) begin
                case ($urandom_range(0, 9))
                    0: b = 8'h00;
                    1: b = 8'hff;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b, 1'b0, '0);
                random_bytes++;
            end
        end

        // Height of zero ends the image at the next row end; later bytes are dropped.
        wait_idle();
        gapless = 1'b0;
        write_reg(bpsr_pkg::CFG_PIXEL_MODE, $urandom_range(0, 1));
        write_reg(bpsr_pkg::CFG_IMAGE_WIDTH, 2);
        write_reg(bpsr_pkg::CFG_IMAGE_HEIGHT, 0);
        repeat (40) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);

        push <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
